// File: hw/rtl/gps_pkg.sv
// Package: shared constants, types and cell bus struct for the palette stop chain.
`timescale 1ns / 1ps
package gps_pkg;
    localparam int MaxStops = 16;
    localparam int MaxPalette = 4096;
    localparam int PosW = 12;
    localparam int SlotW = $clog2(MaxStops);
    localparam int CntW = $clog2(MaxStops + 1);
    localparam int MergeDiv = 50;
    localparam int ColorMax = 255;

    // lookup result source
    localparam logic [1:0] ModeStop   = 2'd0;
    localparam logic [1:0] ModeInterp = 2'd1;

    typedef struct packed {
        logic [PosW-1:0] pos;
        logic [7:0]      red;
        logic [7:0]      green;
        logic [7:0]      blue;
    } stop_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SORT,
        ST_FIND,
        ST_DIV,
        ST_OUT
    } state_t;
endpackage

// File: hw/rtl/gps_cell.sv
// One stop cell: holds one stop and swaps it with a neighbor during the sort.
`timescale 1ns / 1ps
module gps_cell (
    input  logic           clk,
    input  logic           wr_color,
    input  logic           wr_all,
    input  logic           load_right,
    input  logic           load_left,
    input  gps_pkg::stop_t wr_data,
    input  gps_pkg::stop_t right_data,
    input  gps_pkg::stop_t left_data,
    output gps_pkg::stop_t stop
);
    gps_pkg::stop_t stop_reg;
    gps_pkg::stop_t stop_next;

    always_comb
    begin
        stop_next = stop_reg;
        if (wr_all)
        begin
            stop_next = wr_data;
        end
        else if (wr_color)
        begin
            stop_next.red   = wr_data.red;
            stop_next.green = wr_data.green;
            stop_next.blue  = wr_data.blue;
        end
        else if (load_right)
        begin
            stop_next = right_data;
        end
        else if (load_left)
        begin
            stop_next = left_data;
        end
    end

    always_ff @(posedge clk)
    begin
        stop_reg <= stop_next;
    end

    assign stop = stop_reg;
endmodule

// File: hw/rtl/gps_div.sv
// Serial restoring divider for the interpolation step: 20-bit unsigned numerator magnitude, 12-bit span.
`timescale 1ns / 1ps
module gps_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [19:0] num_mag,
    input  logic [11:0] den,
    output logic        busy,
    output logic [19:0] quo
);
    logic [19:0] q_reg;
    logic [12:0] rem_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic [12:0] trial;

    assign trial = {rem_reg[11:0], q_reg[19]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 5'd20;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num_mag;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den})
            begin
                rem_reg <= trial - {1'b0, den};
                q_reg   <= {q_reg[18:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                q_reg   <= {q_reg[18:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign quo  = q_reg;
endmodule

// File: hw/rtl/gradient_palette_stops.sv
// Top level: stop cell chain, sequencer, and serial divider for gradient lookups.
//   channel   dir  handshake               payload
//   s_axis    in   s_axis_tvalid/tready    tdata {blue,green,red,position}, tuser req_type
//   m_axis    out  m_axis_tvalid/tready    tdata {blue,green,red,no_stops,full,merged,slot}
//   cfg       in   palette_size_we         palette_size_wdata
// An add scans the 16 cells one per cycle and registers its result at the end of the scan.
// A lookup takes 16 odd-even transposition passes, a linear search over the cells, and between
// two stops three serial divisions, one per color channel, then the output state.
// A lookup on an empty table answers the next cycle.
// Reset empties the table; one word is in flight at a time and a new word is taken
// only once the previous result is gone. The output register holds its word while
// m_axis_tready is low.
`timescale 1ns / 1ps
module gradient_palette_stops (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        palette_size_we,
    input  logic [12:0] palette_size_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [35:0] s_axis_tdata, // position, red_in, green_in, blue_in
    input  logic        s_axis_tuser, // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata  // slot, merged, table_full, no_stops, r, g, b
);
    localparam int N = gps_pkg::MaxStops;
    localparam int SW = gps_pkg::SlotW;
    localparam int CW = gps_pkg::CntW;

    gps_pkg::state_t state_reg, state_next;
    logic [12:0] psize_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic        phase_reg, phase_next;
    gps_pkg::stop_t req_data_reg;
    logic        hit_reg, hit_next;
    logic [SW-1:0] hit_slot_reg, hit_slot_next;
    logic [SW-1:0] sel_reg, sel_next;
    logic [1:0]  mode_reg, mode_next; // 0 sel color, 1 interpolate
    logic [1:0]  ch_reg, ch_next;
    logic [23:0] color_reg, color_next;
    logic        ovalid_reg, ovalid_next;
    logic [31:0] odata_reg, odata_next;

    gps_pkg::stop_t cells [N];
    logic wr_color [N];
    logic wr_all [N];
    logic ld_r [N];
    logic ld_l [N];

    logic [12:0] eff;
    logic [11:0] pclamp;
    logic [6:0]  mdist;
    assign eff = (psize_reg < 13'd2) ? 13'd2 :
                 (psize_reg > 13'(gps_pkg::MaxPalette)) ? 13'(gps_pkg::MaxPalette) : psize_reg;
    assign mdist = 7'(({12'd0, eff} * 25'd1311) >> 16); // eff/50 for eff <= 4096
    assign pclamp = ({1'b0, s_axis_tdata[11:0]} > eff - 13'd1) ? 12'(eff - 13'd1)
                                                               : s_axis_tdata[11:0];

    // request compare against the scanned cell
    logic [11:0] scan_pos, diff;
    assign scan_pos = cells[idx_reg[SW-1:0]].pos;
    assign diff = (req_data_reg.pos > scan_pos) ? req_data_reg.pos - scan_pos
                                                : scan_pos - req_data_reg.pos;

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            gps_cell u_cell (
                .clk(clk),
                .wr_color(wr_color[g]), .wr_all(wr_all[g]),
                .load_right(ld_r[g]), .load_left(ld_l[g]),
                .wr_data(req_data_reg),
                .right_data(cells[(g + 1) % N]),
                .left_data(cells[(g + N - 1) % N]),
                .stop(cells[g])
            );
        end
    endgenerate

    // odd-even transposition swap decisions
    logic swp [N];
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            swp[i] = 1'b0;
        end
        for (int i = 0; i < N - 1; i++)
        begin
            if ((i % 2) == int'(phase_reg) && (CW'(i + 1) < count_reg) &&
                cells[i].pos > cells[i + 1].pos)
            begin
                swp[i] = 1'b1;
            end
        end
    end

    // divider operands
    logic        div_start, div_busy;
    logic [19:0] div_quo;
    logic [11:0] span, off;
    logic [7:0]  sv, ev;
    logic [8:0]  dmag;
    logic        dneg;
    logic [19:0] nmag;
    logic [SW-1:0] sel1;
    assign sel1 = sel_reg + SW'(1);
    assign span = cells[sel1].pos - cells[sel_reg].pos;
    assign off  = req_data_reg.pos - cells[sel_reg].pos;
    always_comb
    begin
        case (ch_reg)
            2'd0: begin sv = cells[sel_reg].red;   ev = cells[sel1].red;   end
            2'd1: begin sv = cells[sel_reg].green; ev = cells[sel1].green; end
            default: begin sv = cells[sel_reg].blue; ev = cells[sel1].blue; end
        endcase
        dneg = ev < sv;
        dmag = dneg ? {1'b0, sv} - {1'b0, ev} : {1'b0, ev} - {1'b0, sv};
    end
    assign nmag = {8'd0, off} * {11'd0, dmag};

    gps_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .num_mag(nmag), .den(span), .busy(div_busy), .quo(div_quo)
    );

    logic [9:0] vres;
    assign vres = dneg ? {2'b0, sv} - div_quo[9:0] : {2'b0, sv} + div_quo[9:0];

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        phase_next  = phase_reg;
        hit_next    = hit_reg;
        hit_slot_next = hit_slot_reg;
        sel_next    = sel_reg;
        mode_next   = mode_reg;
        ch_next     = ch_reg;
        color_next  = color_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        div_start   = 1'b0;
        s_axis_tready = 1'b0;
        for (int i = 0; i < N; i++)
        begin
            wr_color[i] = 1'b0;
            wr_all[i]   = 1'b0;
            ld_r[i]     = 1'b0;
            ld_l[i]     = 1'b0;
        end
        if (ovalid_reg && m_axis_tready)
        begin
            ovalid_next = 1'b0;
        end
        case (state_reg)
            gps_pkg::ST_IDLE:
            begin
                s_axis_tready = !ovalid_reg;
                if (s_axis_tvalid && !ovalid_reg)
                begin
                    idx_next   = '0;
                    hit_next   = 1'b0;
                    phase_next = 1'b0;
                    state_next = s_axis_tuser ? gps_pkg::ST_SORT : gps_pkg::ST_SCAN;
                    if (s_axis_tuser && count_reg == '0)
                    begin
                        state_next  = gps_pkg::ST_IDLE;
                        ovalid_next = 1'b1;
                        odata_next  = 32'h0000_0040;
                    end
                end
            end
            gps_pkg::ST_SCAN:
            begin
                if (idx_reg < count_reg && !hit_reg &&
                    {12'd0, diff} * {12'd0, diff} < {17'd0, mdist} * {17'd0, mdist})
                begin
                    hit_next = 1'b1;
                    hit_slot_next = idx_reg[SW-1:0];
                end
                idx_next = idx_reg + CW'(1);
                if (idx_reg == CW'(N - 1))
                begin
                    state_next  = gps_pkg::ST_IDLE;
                    ovalid_next = 1'b1;
                    if (hit_next)
                    begin
                        wr_color[hit_slot_next] = 1'b1;
                        odata_next = {26'd0, 1'b0, 1'b1, hit_slot_next};
                    end
                    else if (count_reg == CW'(N))
                    begin
                        odata_next = {26'd0, 2'b10, SW'(0)};
                    end
                    else
                    begin
                        wr_all[count_reg[SW-1:0]] = 1'b1;
                        count_next = count_reg + CW'(1);
                        odata_next = {26'd0, 2'b00, count_reg[SW-1:0]};
                    end
                end
            end
            gps_pkg::ST_SORT:
            begin
                for (int i = 0; i < N - 1; i++)
                begin
                    if (swp[i])
                    begin
                        ld_r[i]     = 1'b1;
                        ld_l[i + 1] = 1'b1;
                    end
                end
                phase_next = !phase_reg;
                idx_next = idx_reg + CW'(1);
                if (idx_reg == CW'(N - 1))
                begin
                    idx_next   = '0;
                    mode_next  = gps_pkg::ModeStop;
                    sel_next   = '0;
                    hit_next   = 1'b0;
                    state_next = gps_pkg::ST_FIND;
                end
            end
            gps_pkg::ST_FIND:
            begin
                // exact match: last wins; else bracket pair s < p < e
                if (idx_reg < count_reg)
                begin
                    if (cells[idx_reg[SW-1:0]].pos == req_data_reg.pos)
                    begin
                        hit_next = 1'b1;
                        sel_next = idx_reg[SW-1:0];
                        mode_next = gps_pkg::ModeStop;
                    end
                    else if (!hit_reg && idx_reg + CW'(1) < count_reg &&
                             cells[idx_reg[SW-1:0]].pos < req_data_reg.pos &&
                             req_data_reg.pos < cells[idx_reg[SW-1:0] + SW'(1)].pos &&
                             mode_reg == gps_pkg::ModeStop && !hit_reg)
                    begin
                        sel_next  = idx_reg[SW-1:0];
                        mode_next = gps_pkg::ModeInterp;
                    end
                end
                idx_next = idx_reg + CW'(1);
                if (idx_reg == CW'(N - 1))
                begin
                    if (hit_next)
                    begin
                        mode_next = gps_pkg::ModeStop;
                    end
                    else if (req_data_reg.pos < cells[0].pos)
                    begin
                        mode_next = gps_pkg::ModeStop;
                        sel_next  = '0;
                    end
                    else if (mode_next != gps_pkg::ModeInterp)
                    begin
                        mode_next = gps_pkg::ModeStop;
                        sel_next  = SW'(count_reg - CW'(1));
                    end
                    ch_next    = 2'd0;
                    phase_next = 1'b0;
                    if (mode_next == gps_pkg::ModeInterp)
                    begin
                        state_next = gps_pkg::ST_DIV;
                    end
                    else
                    begin
                        state_next = gps_pkg::ST_OUT;
                    end
                end
            end
            gps_pkg::ST_DIV:
            begin
                // phase low: launch the division for ch_reg; high: wait for it
                if (!phase_reg)
                begin
                    div_start  = 1'b1;
                    phase_next = 1'b1;
                end
                else if (!div_busy)
                begin
                    case (ch_reg)
                        2'd0: color_next[7:0] = vres[7:0];
                        2'd1: color_next[15:8] = vres[7:0];
                        default: color_next[23:16] = vres[7:0];
                    endcase
                    if (ch_reg == 2'd2)
                    begin
                        state_next = gps_pkg::ST_OUT;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 2'd1;
                        phase_next = 1'b0;
                    end
                end
            end
            gps_pkg::ST_OUT:
            begin
                state_next  = gps_pkg::ST_IDLE;
                ovalid_next = 1'b1;
                if (mode_reg == gps_pkg::ModeInterp)
                begin
                    odata_next = {1'b0, color_reg, 7'd0};
                end
                else
                begin
                    odata_next = {1'b0, cells[sel_reg].blue, cells[sel_reg].green,
                                  cells[sel_reg].red, 7'd0};
                end
            end
            default:
            begin
                state_next = gps_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= gps_pkg::ST_IDLE;
            psize_reg  <= 13'd256;
            count_reg  <= '0;
            idx_reg    <= '0;
            phase_reg  <= 1'b0;
            hit_reg    <= 1'b0;
            mode_reg   <= gps_pkg::ModeStop;
            ch_reg     <= 2'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            phase_reg  <= phase_next;
            hit_reg    <= hit_next;
            mode_reg   <= mode_next;
            ch_reg     <= ch_next;
            ovalid_reg <= ovalid_next;
            if (palette_size_we)
            begin
                psize_reg <= palette_size_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hit_slot_reg <= hit_slot_next;
        sel_reg      <= sel_next;
        color_reg    <= color_next;
        odata_reg    <= odata_next;
        if (state_reg == gps_pkg::ST_IDLE && s_axis_tvalid && s_axis_tready)
        begin
            req_data_reg <= {pclamp, s_axis_tdata[19:12], s_axis_tdata[27:20],
                             s_axis_tdata[35:28]};
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
endmodule
